// ===== rtl/tcc_pkg.sv =====
// Shared types, constants and cursor arithmetic for the text console cursor.
`default_nettype none
package tcc_pkg;

   localparam int MAX_COLUMNS = 256;
   localparam int MAX_ROWS    = 128;
   localparam int COL_LIMIT   = (MAX_COLUMNS < 256) ? MAX_COLUMNS : 256;
   localparam int ROW_LIMIT   = (MAX_ROWS < 128) ? MAX_ROWS : 128;

   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [3:0] TAB_STOP     = 4'd8;

   localparam logic [1:0] REG_TEXT_COLUMNS = 2'd0;
   localparam logic [1:0] REG_TEXT_ROWS    = 2'd1;

   localparam logic [8:0] COLUMNS_RESET = 9'd128;
   localparam logic [7:0] ROWS_RESET    = 8'd48;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_newline;
      logic out_free;
      logic last;
   } status_type;

   typedef struct packed {
      logic [7:0] col;
      logic [6:0] row;
   } cursor_type;

   function automatic logic [8:0] eff_columns(input logic [8:0] cols);
      logic [8:0] c;
      c = cols;
      if (c == 9'd0) begin
         c = 9'd1;
      end
      if (c > 9'(COL_LIMIT)) begin
         c = 9'(COL_LIMIT);
      end
      return c;
   endfunction

   function automatic logic [7:0] eff_rows(input logic [7:0] rows);
      logic [7:0] r;
      r = rows;
      if (r == 8'd0) begin
         r = 8'd1;
      end
      if (r > 8'(ROW_LIMIT)) begin
         r = 8'(ROW_LIMIT);
      end
      return r;
   endfunction

   // bounds check: x and y may be one past range
   function automatic cursor_type settle(input logic [8:0] x, input logic [7:0] y,
                                         input logic [8:0] effc, input logic [7:0] effr);
      cursor_type res;
      logic [8:0] nx;
      logic [7:0] ny;
      nx = x;
      ny = y;
      if (nx >= effc) begin
         ny = ny + 8'd1;
         nx = 9'd0;
      end
      if (ny >= effr) begin
         ny = 8'd0;
      end
      res.col = nx[7:0];
      res.row = ny[6:0];
      return res;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tcc_ctrl.sv =====
// Controller state machine: request intake and cell write sequencing.
`default_nettype none
module tcc_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  tcc_pkg::status_type status,
   output tcc_pkg::cmd_type    cmd
);
   import tcc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !status.is_newline) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (status.out_free && status.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.emit = status.out_free;
         end
         default: req_stall = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/tcc_dp.sv =====
// Datapath: grid registers, cursor, request holding and cell write output register.
`default_nettype none
module tcc_dp (
   input  wire                 clock,
   input  wire                 reset,
   input  tcc_pkg::cmd_type    cmd,
   output tcc_pkg::status_type status,
   input  wire                 csr_valid,
   input  wire  [1:0]          csr_index,
   input  wire  [8:0]          csr_wdata,
   input  wire  [7:0]          req_char_code,
   input  wire  [31:0]         req_fore_color,
   input  wire  [31:0]         req_back_color,
   input  wire                 req_end_of_text,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [7:0]          rsp_cell_glyph,
   output logic [7:0]          rsp_cell_column,
   output logic [6:0]          rsp_cell_row,
   output logic [31:0]         rsp_cell_fore,
   output logic [31:0]         rsp_cell_back,
   output logic                rsp_run_last,
   output logic                rsp_text_done
);
   import tcc_pkg::*;

   logic [8:0]  cols_ff;
   logic [7:0]  rows_ff;
   logic [7:0]  col_ff;
   logic [6:0]  row_ff;
   logic [7:0]  glyph_ff;
   logic [31:0] fore_ff;
   logic [31:0] back_ff;
   logic        eot_ff;
   logic        adv_ff;
   logic [3:0]  count_ff;
   logic        rsp_valid_ff;
   logic [7:0]  out_glyph_ff;
   logic [7:0]  out_col_ff;
   logic [6:0]  out_row_ff;
   logic [31:0] out_fore_ff;
   logic [31:0] out_back_ff;
   logic        out_last_ff;
   logic        out_done_ff;

   logic [8:0]  effc;
   logic [7:0]  effr;
   logic        is_bs;
   logic        is_tab;
   cursor_type  nl_cur;
   cursor_type  bs_cur;
   cursor_type  step_cur;

   assign effc  = eff_columns(cols_ff);
   assign effr  = eff_rows(rows_ff);
   assign is_bs  = (req_char_code == CH_BACKSPACE);
   assign is_tab = (req_char_code == CH_TAB);

   assign status.is_newline = (req_char_code == CH_NEWLINE);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.last       = (count_ff == 4'd1);

   assign nl_cur   = settle(9'd0, {1'b0, row_ff} + 8'd1, effc, effr);
   assign step_cur = settle({1'b0, col_ff} + {8'd0, adv_ff}, {1'b0, row_ff}, effc, effr);

   always_comb begin
      bs_cur.col = col_ff - 8'd1;
      bs_cur.row = row_ff;
      if (col_ff == 8'd0) begin
         bs_cur.col = 8'(effc - 9'd1);
         bs_cur.row = (row_ff == 7'd0) ? 7'(effr - 8'd1) : row_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= COLUMNS_RESET;
         rows_ff <= ROWS_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_TEXT_COLUMNS) begin
            cols_ff <= csr_wdata;
         end else if (csr_index == REG_TEXT_ROWS) begin
            rows_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.load && status.is_newline) begin
         col_ff <= nl_cur.col;
         row_ff <= nl_cur.row;
      end else if (cmd.load && is_bs) begin
         col_ff <= bs_cur.col;
         row_ff <= bs_cur.row;
      end else if (cmd.emit) begin
         col_ff <= step_cur.col;
         row_ff <= step_cur.row;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         glyph_ff <= (is_bs || is_tab) ? CH_SPACE : req_char_code;
         fore_ff  <= req_fore_color;
         back_ff  <= req_back_color;
         eot_ff   <= req_end_of_text;
         adv_ff   <= !is_bs;
         count_ff <= is_tab ? TAB_STOP - {1'b0, col_ff[2:0]} : 4'd1;
      end else if (cmd.emit) begin
         count_ff <= count_ff - 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_glyph_ff <= glyph_ff;
         out_col_ff   <= col_ff;
         out_row_ff   <= row_ff;
         out_fore_ff  <= fore_ff;
         out_back_ff  <= back_ff;
         out_last_ff  <= status.last;
         out_done_ff  <= status.last && eot_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_glyph  = out_glyph_ff;
   assign rsp_cell_column = out_col_ff;
   assign rsp_cell_row    = out_row_ff;
   assign rsp_cell_fore   = out_fore_ff;
   assign rsp_cell_back   = out_back_ff;
   assign rsp_run_last    = out_last_ff;
   assign rsp_text_done   = out_done_ff;

endmodule
`default_nettype wire

// ===== rtl/text_console_cursor.sv =====
// Top level of the text console cursor: controller plus datapath.
// Each request is one character byte with its colors; the block tracks a cursor on a
// text_columns x text_rows grid (registers 0 and 1, reset 128 and 48, clamped to 1..256
// and 1..128) and turns the byte into zero to eight cell writes. Newline only moves the
// cursor and writes nothing; a printable byte or backspace takes an intake step plus one
// cell write; a tab takes an intake step plus one cell write for each of its N = 1..8
// spaces. The single output register issues one cell write per cycle unless rsp_stall
// holds it. A new request is taken once the previous one's last cell write sits in the
// output register. Cursor moves wrap to row 0 past the last row; there is no scrolling.
`default_nettype none
module text_console_cursor (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [1:0]  csr_index,
   input  wire  [8:0]  csr_wdata,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_char_code,
   input  wire  [31:0] req_fore_color,
   input  wire  [31:0] req_back_color,
   input  wire         req_end_of_text,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [7:0]  rsp_cell_glyph,
   output logic [7:0]  rsp_cell_column,
   output logic [6:0]  rsp_cell_row,
   output logic [31:0] rsp_cell_fore,
   output logic [31:0] rsp_cell_back,
   output logic        rsp_run_last,
   output logic        rsp_text_done
);
   import tcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   tcc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_char_code   (req_char_code),
      .req_fore_color  (req_fore_color),
      .req_back_color  (req_back_color),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_glyph  (rsp_cell_glyph),
      .rsp_cell_column (rsp_cell_column),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_fore   (rsp_cell_fore),
      .rsp_cell_back   (rsp_cell_back),
      .rsp_run_last    (rsp_run_last),
      .rsp_text_done   (rsp_text_done)
   );

endmodule
`default_nettype wire
